@@ rtl/core/flip_maneuver_sequencer_top_defines.svh @@
// Assertion macros shared by the flip maneuver sequencer RTL.
`ifndef FLIP_MANEUVER_SEQUENCER_TOP_DEFINES_SVH
`define FLIP_MANEUVER_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fms_pkg.sv @@
// Types and constants of the flip maneuver sequencer.
package fms_pkg;

    localparam int STICK_W = 16;
    localparam int TIME_W  = 32;
    localparam int THR_W   = 13;
    localparam int RATE_W  = 15;
    localparam int GRAV_W  = 16;
    localparam int STAGE_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Item kinds
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;

    // Stages
    localparam logic [STAGE_W-1:0] STG_NONE     = 4'd0;
    localparam logic [STAGE_W-1:0] STG_START    = 4'd1;
    localparam logic [STAGE_W-1:0] STG_THR_UP   = 4'd2;
    localparam logic [STAGE_W-1:0] STG_ROTATE   = 4'd3;
    localparam logic [STAGE_W-1:0] STG_INVERTED = 4'd4;
    localparam logic [STAGE_W-1:0] STG_LEVEL    = 4'd5;
    localparam logic [STAGE_W-1:0] STG_EXIT     = 4'd6;
    localparam logic [STAGE_W-1:0] STG_REVERSE  = 4'd7;
    localparam logic [STAGE_W-1:0] STG_HALF_LVL = 4'd8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_UP_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_TMO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TMO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TIME  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_THR = 3'd6;

    // Throttle levels, Q1.12
    localparam logic [THR_W-1:0] THR_UP    = 13'd3686;
    localparam logic [THR_W-1:0] THR_HOVER = 13'd2048;
    localparam logic [THR_W-1:0] THR_EXIT  = 13'd3277;
    localparam logic [THR_W-1:0] THR_ADD   = 13'd1229;
    localparam logic [THR_W-1:0] THR_FULL  = 13'd4096;

    typedef struct packed {
        logic [1:0]                mode;
        logic [TIME_W-1:0]         time_us;
        logic                      on_ground;
        logic signed [GRAV_W-1:0]  grav_z;
        logic signed [STICK_W-1:0] stick_roll;
        logic signed [STICK_W-1:0] stick_pitch;
        logic signed [STICK_W-1:0] stick_yaw;
        logic [THR_W-1:0]          stick_throttle;
        logic                      pwm_forward;
    } t_in_item;

    typedef struct packed {
        logic                      flipping;
        logic [STAGE_W-1:0]        stage;
        logic                      acro_force;
        logic                      controls_force;
        logic                      level_force;
        logic signed [STICK_W-1:0] out_roll;
        logic signed [STICK_W-1:0] out_pitch;
        logic signed [STICK_W-1:0] out_yaw;
        logic [THR_W-1:0]          out_throttle;
        logic                      motors_reversed;
    } t_out_item;

    typedef struct packed {
        logic [RATE_W-1:0] flip_rate_cmd;
        logic [RATE_W-1:0] halfflip_rate_cmd;
        logic [TIME_W-1:0] spool_up_time;
        logic [TIME_W-1:0] stage_timeout;
        logic [TIME_W-1:0] total_timeout;
        logic [TIME_W-1:0] level_time;
        logic [RATE_W-1:0] upright_threshold;
    } t_cfg;

    // Pilot throttle plus boost, clamped at full scale.
    function automatic logic [THR_W-1:0] sat_thr(input logic [THR_W-1:0] thr);
        logic [THR_W:0] sum;
        sum = {1'b0, thr} + {1'b0, THR_ADD};
        return (sum > {1'b0, THR_FULL}) ? THR_FULL : sum[THR_W-1:0];
    endfunction

endpackage

@@ rtl/core/flip_maneuver_sequencer_top.sv @@
// Top level of the flip maneuver sequencer: beat registers around the stage machine.
//
//   channel   direction  handshake                   payload
//   -------   ---------  --------------------------  ----------------------
//   in        input      i_in_valid / o_in_stall     i_in_item  (t_in_item)
//   out       output     o_out_valid / i_out_stall   o_out_item (t_out_item)
//   cfg       input      i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// An accepted beat lands in the input register; when the output register is
// free or drains, the stage machine steps on it and its result enters the
// output register. One beat is taken every cycle while the output does not stall.
// The stage machine step is combinational between the two registers.
// Reset (synchronous, active low) empties both beat registers and loads the
// register defaults; no clearing pass is needed.
// A stall on the output holds the result; the input stalls only while the
// input register is full and cannot hand its beat on.
module flip_maneuver_sequencer_top
    import fms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "flip_maneuver_sequencer_top_defines.svh"

    t_cfg      cfg;
    t_out_item step_result;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;

    fms_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Step the machine when a beat waits and the output slot frees up.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    fms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // Input register: take a new beat whenever it is empty or drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Output register: load on advance, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `FMS_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_in_valid, "input stalled while input register empty")
    `FMS_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, advance, o_out_valid, "stepped beat did not reach output register")
    `FMS_ASSERT_NEXT(a_taken_drains_out, i_clk, i_rst_n, o_out_valid && !i_out_stall && !advance, !o_out_valid, "output beat repeated")
    `FMS_ASSERT_NOW(a_idle_is_clean, i_clk, i_rst_n, o_out_valid && !o_out_item.flipping, o_out_item.stage == STG_NONE && !o_out_item.acro_force && !o_out_item.controls_force && !o_out_item.level_force, "idle result shows a stage or force flag")

endmodule

@@ rtl/core/fms_cfg_regs.sv @@
// Configuration register bank of the flip maneuver sequencer.
module fms_cfg_regs
    import fms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FLIP_RATE:   n_cfg.flip_rate_cmd     = i_cfg_data[RATE_W-1:0];
                REG_HALF_RATE:   n_cfg.halfflip_rate_cmd = i_cfg_data[RATE_W-1:0];
                REG_THR_UP_TIME: n_cfg.spool_up_time     = i_cfg_data[TIME_W-1:0];
                REG_STAGE_TMO:   n_cfg.stage_timeout     = i_cfg_data[TIME_W-1:0];
                REG_TOTAL_TMO:   n_cfg.total_timeout     = i_cfg_data[TIME_W-1:0];
                REG_LEVEL_TIME:  n_cfg.level_time        = i_cfg_data[TIME_W-1:0];
                REG_UPRIGHT_THR: n_cfg.upright_threshold = i_cfg_data[RATE_W-1:0];
                default: ; // drop writes past the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flip_rate_cmd     <= RATE_W'(17067);
            r_cfg.halfflip_rate_cmd <= RATE_W'(6827);
            r_cfg.spool_up_time     <= TIME_W'(200000);
            r_cfg.stage_timeout     <= TIME_W'(500000);
            r_cfg.total_timeout     <= TIME_W'(1500000);
            r_cfg.level_time        <= TIME_W'(100000);
            r_cfg.upright_threshold <= RATE_W'(200);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/fms_core.sv @@
// Flip stage machine: maneuver state and the per-item step logic.
module fms_core
    import fms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic                      r_active, n_active;
    logic [STAGE_W-1:0]        r_stage, n_stage;
    logic [TIME_W-1:0]         r_start_time, n_start_time;
    logic [TIME_W-1:0]         r_level_start, n_level_start;
    logic                      r_axis_pitch, n_axis_pitch;
    logic                      r_dir_pos, n_dir_pos;
    logic                      r_half, n_half;
    logic                      r_up_fwd, n_up_fwd;
    logic                      r_f_acro, n_f_acro;
    logic                      r_f_ctrl, n_f_ctrl;
    logic                      r_f_level, n_f_level;
    logic signed [STICK_W-1:0] r_ovr_roll, n_ovr_roll;
    logic signed [STICK_W-1:0] r_ovr_pitch, n_ovr_pitch;
    logic signed [STICK_W-1:0] r_ovr_yaw, n_ovr_yaw;
    logic [THR_W-1:0]          r_ovr_thr, n_ovr_thr;
    logic                      r_motor_rev, n_motor_rev;

    logic signed [STICK_W:0]   roll_x, pitch_x, abs_roll, abs_pitch;
    logic signed [GRAV_W:0]    g_x, lim_x;
    logic [TIME_W-1:0]         dt, dt_level;
    logic [TIME_W:0]           rot_limit;
    logic                      inverted, upright;
    logic [STICK_W-1:0]        rate, rate_signed;
    logic [STAGE_W-1:0]        s;

    always_comb begin
        roll_x    = {i_item.stick_roll[STICK_W-1], i_item.stick_roll};
        pitch_x   = {i_item.stick_pitch[STICK_W-1], i_item.stick_pitch};
        abs_roll  = roll_x[STICK_W] ? -roll_x : roll_x;
        abs_pitch = pitch_x[STICK_W] ? -pitch_x : pitch_x;
        g_x       = {i_item.grav_z[GRAV_W-1], i_item.grav_z};
        lim_x     = {2'b00, i_cfg.upright_threshold};
        dt        = i_item.time_us - r_start_time;
        dt_level  = i_item.time_us - r_level_start;
        rot_limit = {1'b0, i_cfg.stage_timeout} + {1'b0, i_cfg.spool_up_time};
        inverted  = r_up_fwd ? (g_x < 0) : (g_x > 0);
        upright   = r_up_fwd ? (g_x > lim_x) : (g_x < -lim_x);
        rate      = r_half ? STICK_W'(i_cfg.halfflip_rate_cmd)
                           : STICK_W'(i_cfg.flip_rate_cmd);
        rate_signed = r_dir_pos ? rate : -rate;
    end

    always_comb begin
        n_active      = r_active;
        n_stage       = r_stage;
        n_start_time  = r_start_time;
        n_level_start = r_level_start;
        n_axis_pitch  = r_axis_pitch;
        n_dir_pos     = r_dir_pos;
        n_half        = r_half;
        n_up_fwd      = r_up_fwd;
        n_f_acro      = r_f_acro;
        n_f_ctrl      = r_f_ctrl;
        n_f_level     = r_f_level;
        n_ovr_roll    = r_ovr_roll;
        n_ovr_pitch   = r_ovr_pitch;
        n_ovr_yaw     = r_ovr_yaw;
        n_ovr_thr     = r_ovr_thr;
        n_motor_rev   = r_motor_rev;
        s             = r_stage;

        if (i_item.mode == MODE_FULL || i_item.mode == MODE_HALF) begin
            // restart unless already running on the ground
            if (!r_active || !i_item.on_ground) begin
                n_active     = 1'b1;
                n_start_time = i_item.time_us;
                n_stage      = STG_START;
            end
            n_up_fwd = i_item.pwm_forward;
            if (i_item.mode == MODE_FULL) begin
                n_half = 1'b0;
                if (abs_roll < abs_pitch) begin
                    n_axis_pitch = 1'b1;
                    n_dir_pos    = i_item.stick_pitch > 0;
                end else begin
                    n_axis_pitch = 1'b0;
                    n_dir_pos    = i_item.stick_roll > 0;
                end
            end else begin
                n_half       = 1'b1;
                n_axis_pitch = 1'b0;
                n_dir_pos    = i_item.stick_roll > 0;
            end
        end else if (i_item.mode == MODE_TICK && r_active) begin
            if (i_item.on_ground || dt > i_cfg.total_timeout) begin
                s = STG_EXIT;
            end
            n_stage = s;
            unique case (s)
                STG_NONE: ;
                STG_START: begin
                    n_f_acro  = 1'b1;
                    n_f_ctrl  = 1'b1;
                    n_f_level = 1'b0;
                    n_ovr_thr = THR_UP;
                    n_stage   = STG_THR_UP;
                    if (!r_half) begin
                        n_ovr_roll  = '0;
                        n_ovr_pitch = '0;
                        n_ovr_yaw   = '0;
                    end else begin
                        n_axis_pitch = 1'b0;
                        if (inverted) begin
                            n_ovr_thr = THR_HOVER;
                            n_stage   = STG_REVERSE;
                        end
                    end
                end
                STG_THR_UP: begin
                    if (r_half) begin
                        n_ovr_roll  = i_item.stick_roll;
                        n_ovr_pitch = i_item.stick_pitch;
                        n_ovr_yaw   = i_item.stick_yaw;
                        n_ovr_thr   = sat_thr(i_item.stick_throttle);
                    end
                    if (dt > i_cfg.spool_up_time) begin
                        if (r_axis_pitch) begin
                            n_ovr_pitch = rate_signed;
                        end else begin
                            n_ovr_roll = rate_signed;
                        end
                        n_ovr_thr = r_half ? THR_HOVER : THR_UP;
                        n_stage   = STG_ROTATE;
                    end
                end
                STG_ROTATE: begin
                    if ({1'b0, dt} > rot_limit) begin
                        n_stage = STG_EXIT;
                    end
                    // inversion wins over the rotation abort
                    if (inverted) begin
                        n_ovr_thr = THR_HOVER;
                        n_stage   = r_half ? STG_REVERSE : STG_INVERTED;
                    end
                end
                STG_INVERTED: begin
                    if (r_half) begin
                        n_stage = STG_EXIT;
                    end else if (upright) begin
                        n_level_start = i_item.time_us;
                        n_ovr_thr     = THR_EXIT;
                        n_f_acro      = 1'b0;
                        n_f_level     = 1'b1;
                        n_stage       = STG_LEVEL;
                    end
                end
                STG_LEVEL: begin
                    if (r_half) begin
                        n_stage = STG_EXIT;
                    end else begin
                        n_ovr_roll  = r_axis_pitch ? i_item.stick_roll : '0;
                        n_ovr_pitch = r_axis_pitch ? '0 : i_item.stick_pitch;
                        n_ovr_yaw   = i_item.stick_yaw;
                        if (dt_level > i_cfg.level_time) begin
                            n_stage = STG_EXIT;
                        end
                    end
                end
                STG_EXIT: begin
                    n_active  = 1'b0;
                    n_stage   = STG_NONE;
                    n_f_acro  = 1'b0;
                    n_f_ctrl  = 1'b0;
                    n_f_level = 1'b0;
                end
                STG_REVERSE: begin
                    if (!r_half) begin
                        n_stage = STG_EXIT;
                    end else begin
                        n_motor_rev   = !r_motor_rev;
                        n_f_acro      = 1'b0;
                        n_f_level     = 1'b1;
                        n_level_start = i_item.time_us;
                        n_stage       = STG_HALF_LVL;
                    end
                end
                STG_HALF_LVL: begin
                    if (!r_half) begin
                        n_stage = STG_EXIT;
                    end else begin
                        n_ovr_roll  = i_item.stick_roll;
                        n_ovr_pitch = i_item.stick_pitch;
                        n_ovr_yaw   = i_item.stick_yaw;
                        n_ovr_thr   = sat_thr(i_item.stick_throttle);
                        if (dt_level > i_cfg.level_time) begin
                            n_stage = STG_EXIT;
                        end
                    end
                end
                default: n_stage = STG_EXIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_stage       <= STG_NONE;
            r_start_time  <= '0;
            r_level_start <= '0;
            r_axis_pitch  <= 1'b0;
            r_dir_pos     <= 1'b0;
            r_half        <= 1'b0;
            r_up_fwd      <= 1'b1;
            r_f_acro      <= 1'b0;
            r_f_ctrl      <= 1'b0;
            r_f_level     <= 1'b0;
            r_ovr_roll    <= '0;
            r_ovr_pitch   <= '0;
            r_ovr_yaw     <= '0;
            r_ovr_thr     <= '0;
            r_motor_rev   <= 1'b0;
        end else if (i_step) begin
            r_active      <= n_active;
            r_stage       <= n_stage;
            r_start_time  <= n_start_time;
            r_level_start <= n_level_start;
            r_axis_pitch  <= n_axis_pitch;
            r_dir_pos     <= n_dir_pos;
            r_half        <= n_half;
            r_up_fwd      <= n_up_fwd;
            r_f_acro      <= n_f_acro;
            r_f_ctrl      <= n_f_ctrl;
            r_f_level     <= n_f_level;
            r_ovr_roll    <= n_ovr_roll;
            r_ovr_pitch   <= n_ovr_pitch;
            r_ovr_yaw     <= n_ovr_yaw;
            r_ovr_thr     <= n_ovr_thr;
            r_motor_rev   <= n_motor_rev;
        end
    end

    // Result shows the state left behind by this item.
    always_comb begin
        o_result.flipping        = n_active;
        o_result.stage           = n_stage;
        o_result.acro_force      = n_f_acro;
        o_result.controls_force  = n_f_ctrl;
        o_result.level_force     = n_f_level;
        o_result.out_roll        = n_ovr_roll;
        o_result.out_pitch       = n_ovr_pitch;
        o_result.out_yaw         = n_ovr_yaw;
        o_result.out_throttle    = n_ovr_thr;
        o_result.motors_reversed = n_motor_rev;
    end

endmodule
